### sv/ctts_pkg.sv
// Shared types, constants and helpers for the capacitive touch charge time sensor.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ctts_pkg;

   // Widths fixed by the register map and by the word fields.
   localparam int CFG_W   = 20;
   localparam int CSR_IX_W = 2;
   localparam int COUNT_W = 4;
   localparam int ID_W    = 3;
   localparam int EV_W    = 2;

   // Results per window end are bounded by the button id range.
   localparam int RESULT_LIMIT = 8;

   // Parameter defaults for the top level.
   localparam int DEF_MAX_BUTTONS = 8;
   localparam int DEF_TIME_WIDTH  = 20;

   // Register values after reset.
   localparam logic [CFG_W-1:0]   RST_PRESS_THRESHOLD = 20'd50;
   localparam logic [CFG_W-1:0]   RST_WINDOW_LENGTH   = 20'd100000;
   localparam logic [COUNT_W-1:0] RST_BUTTON_COUNT    = 4'd0;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [CSR_IX_W-1:0] {
      CSR_PRESS_THRESHOLD = 2'd0,
      CSR_WINDOW_LENGTH   = 2'd1,
      CSR_BUTTON_COUNT    = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_TICK = 1'b0,
      REQ_EDGE = 1'b1
   } req_kind_type;

   typedef enum logic [EV_W-1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_HOLD    = 2'd2,
      EV_RELEASE = 2'd3
   } event_type;

   // Work the back has to carry out for one accepted word.
   typedef enum logic [1:0] {
      OP_EDGE = 2'd0,
      OP_OPEN = 2'd1,
      OP_CONT = 2'd2,
      OP_END  = 2'd3
   } op_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_WALK = 1'b1
   } back_state_type;

   typedef struct packed {
      op_type          op;
      logic [ID_W-1:0] idx;
   } cmd_type;

   // Number of buttons in use: the programmed count limited by storage and id range.
   function automatic logic [COUNT_W-1:0] in_use(input logic [COUNT_W-1:0] count,
                                                 input int unsigned max_buttons);
      int unsigned lim;
      lim = (max_buttons < RESULT_LIMIT) ? max_buttons : RESULT_LIMIT;
      if (int'(count) > lim) begin
         return COUNT_W'(lim);
      end
      return count;
   endfunction

endpackage

`default_nettype wire

### sv/ctts_req_if.sv
// Request channel: valid/ready handshake carrying one tick or edge word.
// Depends on ctts_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ctts_req_if;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [ctts_pkg::ID_W-1:0] button_index;

   modport source (output valid, output req_type, output button_index, input ready);
   modport sink   (input valid, input req_type, input button_index, output ready);
endinterface

`default_nettype wire

### sv/ctts_rsp_if.sv
// Response channel: valid/ready handshake carrying one event word.
// Depends on ctts_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ctts_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      pulse_level;
   logic [ctts_pkg::ID_W-1:0] button_id;
   logic [ctts_pkg::EV_W-1:0] event_code;
   logic                      last_of_run;

   modport source (output valid, output pulse_level, output button_id,
                   output event_code, output last_of_run, input ready);
   modport sink   (input valid, input pulse_level, input button_id,
                   input event_code, input last_of_run, output ready);
endinterface

`default_nettype wire

### sv/cap_touch_charge_time_sensor.sv
// Charge time touch sensor top level. A tick word's response word passes through the
// command queue and the response register; edges give no response.
// Throughput: one word per cycle into a four-entry command queue while it is not full;
// the back handles an edge or tick directly and walks the buttons in use at a window end,
// one response word per cycle while the sink is ready, held in the single output register.
// Synchronous active-high reset restores register defaults and clears all but payload data.
`timescale 1ns / 1ps
`default_nettype none

module cap_touch_charge_time_sensor #(
   parameter int MAX_BUTTONS = ctts_pkg::DEF_MAX_BUTTONS,
   parameter int TIME_WIDTH  = ctts_pkg::DEF_TIME_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ctts_req_if.sink                           req_chan,
   ctts_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [ctts_pkg::CSR_IX_W-1:0] csr_index,
   input  wire logic [ctts_pkg::CFG_W-1:0]    csr_wr_data
);

   logic [ctts_pkg::CFG_W-1:0]   press_threshold_ff, press_threshold_in;
   logic [ctts_pkg::CFG_W-1:0]   window_length_ff, window_length_in;
   logic [ctts_pkg::COUNT_W-1:0] button_count_ff, button_count_in;

   logic                  push;
   ctts_pkg::cmd_type     push_cmd;
   logic [TIME_WIDTH-1:0] push_time;
   logic                  q_full;
   logic                  q_valid;
   ctts_pkg::cmd_type     q_cmd;
   logic [TIME_WIDTH-1:0] q_time;
   logic                  q_pop;

   // Configuration register writes.
   always_comb begin
      press_threshold_in = press_threshold_ff;
      window_length_in   = window_length_ff;
      button_count_in    = button_count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ctts_pkg::CSR_PRESS_THRESHOLD: press_threshold_in = csr_wr_data;
            ctts_pkg::CSR_WINDOW_LENGTH:   window_length_in   = csr_wr_data;
            ctts_pkg::CSR_BUTTON_COUNT:
               button_count_in = csr_wr_data[ctts_pkg::COUNT_W-1:0];
            default: press_threshold_in = press_threshold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_threshold_ff <= ctts_pkg::RST_PRESS_THRESHOLD;
         window_length_ff   <= ctts_pkg::RST_WINDOW_LENGTH;
         button_count_ff    <= ctts_pkg::RST_BUTTON_COUNT;
      end else begin
         press_threshold_ff <= press_threshold_in;
         window_length_ff   <= window_length_in;
         button_count_ff    <= button_count_in;
      end
   end

   ctts_front #(
      .MAX_BUTTONS (MAX_BUTTONS),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .window_length (window_length_ff),
      .button_count  (button_count_ff),
      .q_full        (q_full),
      .push          (push),
      .push_cmd      (push_cmd),
      .push_time     (push_time)
   );

   ctts_queue #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .push_time (push_time),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd),
      .pop_time  (q_time),
      .pop       (q_pop)
   );

   ctts_back #(
      .MAX_BUTTONS (MAX_BUTTONS),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_time          (q_time),
      .q_pop           (q_pop),
      .press_threshold (press_threshold_ff),
      .button_count    (button_count_ff),
      .rsp_chan        (rsp_chan)
   );

endmodule

`default_nettype wire

### sv/ctts_queue.sv
// Small command queue between the front and the back of the touch sensor.
// Depends on ctts_pkg for the command type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module ctts_queue #(
   parameter int TIME_WIDTH = ctts_pkg::DEF_TIME_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire ctts_pkg::cmd_type     push_cmd,
   input  wire logic [TIME_WIDTH-1:0] push_time,
   output logic                       full,
   output logic                       pop_valid,
   output ctts_pkg::cmd_type          pop_cmd,
   output logic [TIME_WIDTH-1:0]      pop_time,
   input  wire logic                  pop
);

   localparam int PW = ctts_pkg::QPTR_W;

   ctts_pkg::cmd_type     cmd_ff  [ctts_pkg::QUEUE_DEPTH];
   logic [TIME_WIDTH-1:0] time_ff [ctts_pkg::QUEUE_DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PW:0]           count_ff, count_in;

   // Status toward both sides.
   assign full      = (count_ff == (PW+1)'(ctts_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = cmd_ff[rd_ptr_ff];
   assign pop_time  = time_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; no reset needed for payload.
   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff]  <= push_cmd;
         time_ff[wr_ptr_ff] <= push_time;
      end
   end

endmodule

`default_nettype wire

### sv/ctts_front.sv
// Front of the touch sensor: accepts request words, keeps the window timer and
// turns each word into a command for the back. Depends on ctts_pkg and ctts_req_if.
`timescale 1ns / 1ps
`default_nettype none

module ctts_front #(
   parameter int MAX_BUTTONS = ctts_pkg::DEF_MAX_BUTTONS,
   parameter int TIME_WIDTH  = ctts_pkg::DEF_TIME_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ctts_req_if.sink                                 req_chan,
   input  wire logic [ctts_pkg::CFG_W-1:0]          window_length,
   input  wire logic [ctts_pkg::COUNT_W-1:0]        button_count,
   input  wire logic                                q_full,
   output logic                                     push,
   output ctts_pkg::cmd_type                        push_cmd,
   output logic [TIME_WIDTH-1:0]                    push_time
);

   localparam int CW = (TIME_WIDTH > ctts_pkg::CFG_W) ? TIME_WIDTH : ctts_pkg::CFG_W;

   logic                        measuring_ff, measuring_in;
   logic [TIME_WIDTH-1:0]       elapsed_ff, elapsed_in;
   logic                        accept;
   logic                        is_edge;
   logic [ctts_pkg::COUNT_W-1:0] n_use;
   logic [TIME_WIDTH-1:0]       elapsed_inc;
   logic                        window_done;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign is_edge        = (req_chan.req_type == ctts_pkg::REQ_EDGE);
   assign n_use          = ctts_pkg::in_use(button_count, MAX_BUTTONS);

   // Saturating elapsed count and window end compare.
   always_comb begin
      elapsed_inc = (elapsed_ff != '1) ? elapsed_ff + TIME_WIDTH'(1) : elapsed_ff;
      window_done = (CW'(elapsed_inc) >= CW'(TIME_WIDTH'(window_length)));
   end

   // Classify the word and work out the timer update.
   always_comb begin
      push_cmd.idx = req_chan.button_index;
      push_time    = elapsed_ff;
      measuring_in = measuring_ff;
      elapsed_in   = elapsed_ff;
      push         = 1'b0;
      if (is_edge) begin
         push_cmd.op = ctts_pkg::OP_EDGE;
         push        = accept &&
                       ({1'b0, req_chan.button_index} < n_use);
      end else if (!measuring_ff) begin
         push_cmd.op = ctts_pkg::OP_OPEN;
         push        = accept;
         if (accept) begin
            measuring_in = 1'b1;
            elapsed_in   = '0;
         end
      end else if (window_done) begin
         push_cmd.op = ctts_pkg::OP_END;
         push        = accept;
         if (accept) begin
            measuring_in = 1'b0;
            elapsed_in   = elapsed_inc;
         end
      end else begin
         push_cmd.op = ctts_pkg::OP_CONT;
         push        = accept;
         if (accept) begin
            elapsed_in = elapsed_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         measuring_ff <= 1'b0;
         elapsed_ff   <= '0;
      end else begin
         measuring_ff <= measuring_in;
         elapsed_ff   <= elapsed_in;
      end
   end

endmodule

`default_nettype wire

### sv/ctts_back.sv
// Back of the touch sensor: holds the stored intervals and pressed flags, carries
// out queued commands and drives the response register. Depends on ctts_pkg, ctts_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module ctts_back #(
   parameter int MAX_BUTTONS = ctts_pkg::DEF_MAX_BUTTONS,
   parameter int TIME_WIDTH  = ctts_pkg::DEF_TIME_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   input  wire ctts_pkg::cmd_type             q_cmd,
   input  wire logic [TIME_WIDTH-1:0]         q_time,
   output logic                               q_pop,
   input  wire logic [ctts_pkg::CFG_W-1:0]    press_threshold,
   input  wire logic [ctts_pkg::COUNT_W-1:0]  button_count,
   ctts_rsp_if.source                         rsp_chan
);

   localparam int CW    = (TIME_WIDTH > ctts_pkg::CFG_W) ? TIME_WIDTH : ctts_pkg::CFG_W;
   localparam int IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
   localparam int ID_W  = ctts_pkg::ID_W;

   ctts_pkg::back_state_type state_ff, state_in;
   logic [ID_W-1:0]          walk_ff, walk_in;
   logic [TIME_WIDTH-1:0]    interval_ff [MAX_BUTTONS];
   logic                     pressed_ff  [MAX_BUTTONS];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     pulse_ff, pulse_in;
   logic [ID_W-1:0]          id_ff, id_in;
   ctts_pkg::event_type      ev_ff, ev_in;
   logic                     last_ff, last_in;

   logic [ctts_pkg::COUNT_W-1:0] n_use;
   logic                     out_free;
   logic                     load;
   logic [ID_W-1:0]          rd_sel;
   logic [IDX_W-1:0]         rd_idx;
   logic [TIME_WIDTH-1:0]    cur_v;
   logic                     cur_f;
   logic                     touched;
   logic                     walk_last;
   logic                     clear_all;
   logic                     wr_en;
   logic [TIME_WIDTH-1:0]    wr_data;
   logic                     flag_wr;
   logic                     flag_val;

   assign n_use    = ctts_pkg::in_use(button_count, MAX_BUTTONS);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // One shared entry address: the walk position during a window end, else the edge button.
   always_comb begin
      rd_sel    = (state_ff == ctts_pkg::BK_WALK) ? walk_ff : q_cmd.idx;
      rd_idx    = IDX_W'(rd_sel);
      cur_v     = interval_ff[rd_idx];
      cur_f     = pressed_ff[rd_idx];
      touched   = (CW'(cur_v) > CW'(press_threshold)) || (cur_v == '0);
      walk_last = (({1'b0, walk_ff} + ctts_pkg::COUNT_W'(1)) == n_use);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctts_pkg::BK_IDLE: begin
            if (q_valid && (q_cmd.op == ctts_pkg::OP_END) && (n_use != '0)) begin
               state_in = ctts_pkg::BK_WALK;
            end
         end
         ctts_pkg::BK_WALK: begin
            if (out_free && walk_last) begin
               state_in = ctts_pkg::BK_IDLE;
            end
         end
         default: state_in = ctts_pkg::BK_IDLE;
      endcase
   end

   // Command execution and response loading.
   always_comb begin
      q_pop     = 1'b0;
      load      = 1'b0;
      pulse_in  = pulse_ff;
      id_in     = id_ff;
      ev_in     = ev_ff;
      last_in   = last_ff;
      walk_in   = walk_ff;
      clear_all = 1'b0;
      wr_en     = 1'b0;
      wr_data   = '0;
      flag_wr   = 1'b0;
      flag_val  = 1'b0;
      case (state_ff)
         ctts_pkg::BK_IDLE: begin
            if (q_valid) begin
               case (q_cmd.op)
                  ctts_pkg::OP_EDGE: begin
                     // Only an edge that finds the stored interval still zero is kept.
                     q_pop = 1'b1;
                     if (cur_v == '0) begin
                        wr_en   = 1'b1;
                        wr_data = q_time;
                     end
                  end
                  ctts_pkg::OP_OPEN: begin
                     if (out_free) begin
                        q_pop     = 1'b1;
                        clear_all = 1'b1;
                        load      = 1'b1;
                        pulse_in  = 1'b1;
                        id_in     = '0;
                        ev_in     = ctts_pkg::EV_NONE;
                        last_in   = 1'b1;
                     end
                  end
                  ctts_pkg::OP_CONT: begin
                     if (out_free) begin
                        q_pop    = 1'b1;
                        load     = 1'b1;
                        pulse_in = 1'b1;
                        id_in    = '0;
                        ev_in    = ctts_pkg::EV_NONE;
                        last_in  = 1'b1;
                     end
                  end
                  ctts_pkg::OP_END: begin
                     if (n_use == '0) begin
                        // No buttons in use: a single closing word.
                        if (out_free) begin
                           q_pop    = 1'b1;
                           load     = 1'b1;
                           pulse_in = 1'b0;
                           id_in    = '0;
                           ev_in    = ctts_pkg::EV_NONE;
                           last_in  = 1'b1;
                        end
                     end else begin
                        q_pop   = 1'b1;
                        walk_in = '0;
                     end
                  end
                  default: q_pop = 1'b0;
               endcase
            end
         end
         ctts_pkg::BK_WALK: begin
            // Classify one button per free output slot.
            if (out_free) begin
               load     = 1'b1;
               pulse_in = 1'b0;
               id_in    = walk_ff;
               last_in  = walk_last;
               walk_in  = walk_ff + ID_W'(1);
               flag_wr  = 1'b1;
               if (touched) begin
                  if (cur_f) begin
                     ev_in    = ctts_pkg::EV_HOLD;
                     flag_val = 1'b1;
                  end else begin
                     ev_in    = ctts_pkg::EV_PRESS;
                     flag_val = 1'b1;
                     wr_en    = 1'b1;
                  end
               end else begin
                  ev_in    = cur_f ? ctts_pkg::EV_RELEASE : ctts_pkg::EV_NONE;
                  flag_val = 1'b0;
                  wr_en    = 1'b1;
               end
            end
         end
         default: q_pop = 1'b0;
      endcase
   end

   // Response register holds a word until the sink takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pulse_level = pulse_ff;
   assign rsp_chan.button_id   = id_ff;
   assign rsp_chan.event_code  = ev_ff;
   assign rsp_chan.last_of_run = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctts_pkg::BK_IDLE;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pulse_ff <= pulse_in;
         id_ff    <= id_in;
         ev_ff    <= ev_in;
         last_ff  <= last_in;
      end
   end

   // Per-button interval and pressed flag storage.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_BUTTONS; i++) begin
         if (reset) begin
            interval_ff[i] <= '0;
            pressed_ff[i]  <= 1'b0;
         end else begin
            if (clear_all && (i < int'(n_use))) begin
               interval_ff[i] <= '0;
            end else if (wr_en && (rd_idx == IDX_W'(i))) begin
               interval_ff[i] <= wr_data;
            end
            if (flag_wr && (rd_idx == IDX_W'(i))) begin
               pressed_ff[i] <= flag_val;
            end
         end
      end
   end

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the capacitive touch charge time sensor.
// Depends on ctts_pkg, ctts_req_if, ctts_rsp_if and cap_touch_charge_time_sensor from the RTL.
// Words are driven and checked against an in-bench predictor of the window and button logic.
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_BUTTONS    = ctts_pkg::DEF_MAX_BUTTONS;
   localparam int TIME_W         = ctts_pkg::DEF_TIME_WIDTH;
   localparam int RANDOM_WORDS   = 120;
   localparam int DRAIN_CYCLES   = 16;
   localparam int LONG_HOLD      = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      ctts_pkg::req_kind_type          kind;
      logic [ctts_pkg::ID_W-1:0]       idx;
   } req_word_type;

   typedef struct packed {
      logic                            pulse;
      logic [ctts_pkg::ID_W-1:0]       id;
      ctts_pkg::event_type             ev;
      logic                            last;
   } event_word_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_wr_en = 1'b0;
   logic [ctts_pkg::CSR_IX_W-1:0]     csr_index = '0;
   logic [ctts_pkg::CFG_W-1:0]        csr_wr_data = '0;

   ctts_req_if req_chan ();
   ctts_rsp_if rsp_chan ();

   cap_touch_charge_time_sensor dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stimulus and scoreboard storage.
   req_word_type   pending_words [$];
   event_word_type expected_events [$];
   req_word_type   next_word;

   // Predictor copy of the registers and of the sensing state.
   logic [ctts_pkg::CFG_W-1:0]   cfg_threshold;
   logic [ctts_pkg::CFG_W-1:0]   cfg_window;
   logic [ctts_pkg::COUNT_W-1:0] cfg_count;
   bit                           in_window;
   logic [TIME_W-1:0]            elapsed_us;
   logic [TIME_W-1:0]            charge_time [MAX_BUTTONS];
   bit                           pressed [MAX_BUTTONS];

   // Handshake flags and flow control.
   bit req_fire, rsp_fire, req_busy, gaps_on;
   int send_gap, stall_left, hold_left;
   int holds_asked, holds_served;
   int quiet_cycles;

   // Run statistics.
   int words_queued, ticks_sent, edges_sent, events_checked, windows_closed;
   int settings_written, mismatches;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void note_mismatch(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("mismatch at %0t ns:%s", $time, what);
   endfunction

   function automatic void expect_event(logic pulse, logic [ctts_pkg::ID_W-1:0] id,
                                        ctts_pkg::event_type ev, logic last);
      event_word_type w;
      w.pulse = pulse;
      w.id    = id;
      w.ev    = ev;
      w.last  = last;
      expected_events.push_back(w);
   endfunction

   // Predict the event words caused by one accepted word and advance the sensing state.
   function automatic void predict_sense(ctts_pkg::req_kind_type kind,
                                         logic [ctts_pkg::ID_W-1:0] idx);
      int unsigned active;
      ctts_pkg::event_type ev;
      active = (cfg_count > MAX_BUTTONS) ? MAX_BUTTONS : cfg_count;
      if (active > ctts_pkg::RESULT_LIMIT) active = ctts_pkg::RESULT_LIMIT;

      // An edge latches the elapsed count only while the stored time is zero, even while idle.
      if (kind == ctts_pkg::REQ_EDGE) begin
         edges_sent++;
         if (idx < active && charge_time[idx] == '0) charge_time[idx] = elapsed_us;
         return;
      end
      ticks_sent++;

      // A tick while idle opens a window and raises the pulse.
      if (!in_window) begin
         for (int b = 0; b < int'(active); b++) charge_time[b] = '0;
         elapsed_us = '0;
         in_window  = 1'b1;
         expect_event(1'b1, '0, ctts_pkg::EV_NONE, 1'b1);
         return;
      end

      // Inside a window the count saturates; the pulse stays high until the length is met.
      if (elapsed_us != '1) elapsed_us++;
      if (elapsed_us < cfg_window) begin
         expect_event(1'b1, '0, ctts_pkg::EV_NONE, 1'b1);
         return;
      end

      in_window = 1'b0;
      windows_closed++;
      if (active == 0) begin
         expect_event(1'b0, '0, ctts_pkg::EV_NONE, 1'b1);
         return;
      end

      // Classify each button in use; no edge at all counts as touched.
      for (int b = 0; b < int'(active); b++) begin
         ev = ctts_pkg::EV_NONE;
         if (charge_time[b] > cfg_threshold || charge_time[b] == '0) begin
            if (pressed[b]) begin
               ev = ctts_pkg::EV_HOLD;
            end else begin
               pressed[b]     = 1'b1;
               ev             = ctts_pkg::EV_PRESS;
               charge_time[b] = '0;
            end
         end else begin
            if (pressed[b]) ev = ctts_pkg::EV_RELEASE;
            pressed[b]     = 1'b0;
            charge_time[b] = '0;
         end
         expect_event(1'b0, b[ctts_pkg::ID_W-1:0], ev, (b + 1 == int'(active)));
      end
   endfunction

   // Compare one accepted event word with the oldest prediction, field by field.
   function automatic void check_event_word();
      event_word_type seen, want;
      string diffs;
      seen.pulse = rsp_chan.pulse_level;
      seen.id    = rsp_chan.button_id;
      seen.ev    = ctts_pkg::event_type'(rsp_chan.event_code);
      seen.last  = rsp_chan.last_of_run;
      events_checked++;
      if (expected_events.size() == 0) begin
         note_mismatch($sformatf(" unexpected event word: pulse %0b id %0d event %0d last %0b",
                                 seen.pulse, seen.id, seen.ev, seen.last));
         return;
      end
      want  = expected_events.pop_front();
      diffs = "";
      if (seen.pulse !== want.pulse)
         diffs = {diffs, $sformatf(" pulse_level exp %0b got %0b", want.pulse, seen.pulse)};
      if (seen.id !== want.id)
         diffs = {diffs, $sformatf(" button_id exp %0d got %0d", want.id, seen.id)};
      if (seen.ev !== want.ev)
         diffs = {diffs, $sformatf(" event_code exp %0d got %0d", want.ev, seen.ev)};
      if (seen.last !== want.last)
         diffs = {diffs, $sformatf(" last_of_run exp %0b got %0b", want.last, seen.last)};
      if (diffs != "") note_mismatch(diffs);
   endfunction

   // Sample both channels at the rising edge.
   always @(posedge clock) begin
      req_fire <= !reset && req_chan.valid && req_chan.ready;
      rsp_fire <= !reset && rsp_chan.valid && rsp_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         predict_sense(ctts_pkg::req_kind_type'(req_chan.req_type), req_chan.button_index);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         check_event_word();
      end
   end

   // Request driver: one word at a time from the pending queue, with random gaps.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_busy && req_fire) begin
            req_busy = 1'b0;
            send_gap = gaps_on ? pick_gap() : 0;
         end
         if (!req_busy) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_words.size() > 0) begin
               next_word = pending_words.pop_front();
               req_busy  = 1'b1;
            end
         end
         req_chan.valid <= req_busy;
         if (req_busy) begin
            req_chan.req_type     <= next_word.kind;
            req_chan.button_index <= next_word.idx;
         end else begin
            req_chan.req_type     <= 1'($urandom);
            req_chan.button_index <= ctts_pkg::ID_W'($urandom);
         end
      end
   end

   // Response ready: short random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire && gaps_on) begin
            stall_left = pick_gap();
         end else if (gaps_on && stall_left == 0 && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 3);
         end
         if (holds_served != holds_asked) begin
            hold_left    = LONG_HOLD;
            holds_served = holds_asked;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no word moves for too long.
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no word moved for %0d cycles, %0d event words still predicted",
                  quiet_cycles, expected_events.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void add_word(ctts_pkg::req_kind_type kind, int idx);
      req_word_type w;
      w.kind = kind;
      w.idx  = idx[ctts_pkg::ID_W-1:0];
      pending_words.push_back(w);
      words_queued++;
   endfunction

   // One window: an opening tick, then ticks up to the length with edges in between.
   // A cut window stops early and leaves the sensor measuring.
   function automatic void add_window(bit cut_short);
      int ticks;
      int n_edges;
      int top;
      ticks = (cfg_window == '0) ? 1 : int'(cfg_window);
      if (cut_short) ticks = $urandom_range(0, ticks - 1);
      top = (cfg_count == 0) ? 0 : ((cfg_count > MAX_BUTTONS) ? MAX_BUTTONS - 1 : cfg_count - 1);
      add_word(ctts_pkg::REQ_TICK, $urandom_range(0, 7));
      for (int t = 0; t < ticks; t++) begin
         n_edges = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 2) : 0;
         repeat (n_edges) begin
            if ($urandom_range(0, 4) == 0) add_word(ctts_pkg::REQ_EDGE, $urandom_range(0, 7));
            else add_word(ctts_pkg::REQ_EDGE, $urandom_range(0, top));
         end
         add_word(ctts_pkg::REQ_TICK, $urandom_range(0, 7));
      end
   endfunction

   // Wait until every word is sent and every prediction is met, then let the back settle.
   task automatic wait_quiet();
      while (pending_words.size() > 0 || req_busy || expected_events.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Program all three registers once the sensor has gone quiet.
   task automatic program_sensor(logic [ctts_pkg::CFG_W-1:0] thr,
                                 logic [ctts_pkg::CFG_W-1:0] win,
                                 logic [ctts_pkg::COUNT_W-1:0] cnt);
      wait_quiet();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= ctts_pkg::CSR_PRESS_THRESHOLD;
      csr_wr_data <= thr;
      @(negedge clock);
      csr_index   <= ctts_pkg::CSR_WINDOW_LENGTH;
      csr_wr_data <= win;
      @(negedge clock);
      csr_index   <= ctts_pkg::CSR_BUTTON_COUNT;
      csr_wr_data <= {16'($urandom), cnt};
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cfg_threshold = thr;
      cfg_window    = win;
      cfg_count     = cnt;
      settings_written++;
   endtask

   initial begin
      int r;
      int phase_no;
      int random_start;
      logic [ctts_pkg::CFG_W-1:0] thr, win;
      logic [ctts_pkg::COUNT_W-1:0] cnt;

      req_chan.valid        = 1'b0;
      req_chan.req_type     = 1'b0;
      req_chan.button_index = '0;
      rsp_chan.ready        = 1'b0;
      cfg_threshold = ctts_pkg::RST_PRESS_THRESHOLD;
      cfg_window    = ctts_pkg::RST_WINDOW_LENGTH;
      cfg_count     = ctts_pkg::RST_BUTTON_COUNT;
      in_window     = 1'b0;
      elapsed_us    = '0;
      charge_time   = '{default: '0};
      pressed       = '{default: 1'b0};
      gaps_on       = 1'b1;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Edge while idle, edge at elapsed zero, a repeated edge, presses and a plain none.
      program_sensor(20'd1, 20'd3, 4'd8);
      add_word(ctts_pkg::REQ_EDGE, 7);
      add_word(ctts_pkg::REQ_TICK, 0);
      add_word(ctts_pkg::REQ_EDGE, 0);
      add_word(ctts_pkg::REQ_TICK, 7);
      add_word(ctts_pkg::REQ_EDGE, 1);
      add_word(ctts_pkg::REQ_TICK, 0);
      add_word(ctts_pkg::REQ_EDGE, 2);
      add_word(ctts_pkg::REQ_EDGE, 2);
      add_word(ctts_pkg::REQ_TICK, 5);

      // Second window: a release, a hold on a late edge, a press and holds with no edge.
      add_word(ctts_pkg::REQ_TICK, 0);
      add_word(ctts_pkg::REQ_TICK, 0);
      add_word(ctts_pkg::REQ_EDGE, 2);
      add_word(ctts_pkg::REQ_TICK, 0);
      add_word(ctts_pkg::REQ_EDGE, 0);
      add_word(ctts_pkg::REQ_TICK, 0);

      // No buttons in use: an edge is ignored and the window end gives one word.
      program_sensor(20'd0, 20'd1, 4'd0);
      add_word(ctts_pkg::REQ_TICK, 0);
      add_word(ctts_pkg::REQ_EDGE, 3);
      add_word(ctts_pkg::REQ_TICK, 0);

      // Count above the limit, zero window length and the largest threshold.
      program_sensor(20'hFFFFF, 20'd0, 4'd15);
      add_word(ctts_pkg::REQ_TICK, 0);
      add_word(ctts_pkg::REQ_TICK, 0);

      // Longest window, left open so that it runs on under the next settings.
      program_sensor(20'd0, 20'hFFFFF, 4'd9);
      add_word(ctts_pkg::REQ_TICK, 0);
      add_word(ctts_pkg::REQ_EDGE, 4);
      add_word(ctts_pkg::REQ_TICK, 0);
      add_word(ctts_pkg::REQ_EDGE, 6);
      add_word(ctts_pkg::REQ_TICK, 0);

      // Random phases: mostly whole windows with random edges, some cut short, some noise.
      random_start = words_queued;
      phase_no = 0;
      while (words_queued - random_start < RANDOM_WORDS) begin
         phase_no++;
         r = $urandom_range(0, 99);
         cnt = (r < 10) ? 4'd0 : ((r < 20) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8)));
         r = $urandom_range(0, 99);
         win = (r < 8) ? 20'd0 : ((r < 16) ? 20'd1 : 20'($urandom_range(2, 12)));
         r = $urandom_range(0, 99);
         thr = (r < 10) ? 20'd0 : ((r < 20) ? 20'hFFFFF : 20'($urandom_range(0, int'(win))));
         program_sensor(thr, win, cnt);
         gaps_on = ($urandom_range(0, 3) != 0);

         // One phase holds the response side off long enough to back up the input.
         if (phase_no == 2) begin
            gaps_on = 1'b0;
            holds_asked++;
            repeat (3) add_window(1'b0);
         end else begin
            repeat ($urandom_range(1, 3)) begin
               repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
                  add_word(ctts_pkg::REQ_EDGE, $urandom_range(0, 7));
               add_window($urandom_range(0, 5) == 0);
            end
         end
      end

      wait_quiet();
      $display("Drove %0d words (%0d ticks, %0d edges) under %0d register settings.",
               ticks_sent + edges_sent, ticks_sent, edges_sent, settings_written);
      $display("Checked %0d event words over %0d closed windows, %0d mismatches.",
               events_checked, windows_closed, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
